### src/sct_pkg.sv
// types, constants and byte classification shared by the tokenizer modules
package sct_pkg;

    // token kind codes
    localparam logic [3:0] KIND_WORD       = 4'd0;
    localparam logic [3:0] KIND_PIPE       = 4'd1;
    localparam logic [3:0] KIND_OR         = 4'd2;
    localparam logic [3:0] KIND_BACKGROUND = 4'd3;
    localparam logic [3:0] KIND_AND        = 4'd4;
    localparam logic [3:0] KIND_IN         = 4'd5;
    localparam logic [3:0] KIND_HEREDOC    = 4'd6;
    localparam logic [3:0] KIND_HERESTRING = 4'd7;
    localparam logic [3:0] KIND_OUT        = 4'd8;
    localparam logic [3:0] KIND_APPEND     = 4'd9;
    localparam logic [3:0] KIND_CLOBBER    = 4'd10;
    localparam logic [3:0] KIND_LPAREN     = 4'd11;
    localparam logic [3:0] KIND_RPAREN     = 4'd12;
    localparam logic [3:0] KIND_SEMICOLON  = 4'd13;

    // special bytes
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // most results one byte can cause
    localparam int MAX_RES = 3;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       has_byte;
        logic       token_end;
        logic [3:0] token_kind;
        logic       run_last;
    } token_item_t;

    // one result without its run marker
    typedef struct packed {
        logic [7:0] text_byte;
        logic       has_byte;
        logic       token_end;
        logic [3:0] token_kind;
    } res_t;

    // all results of one byte, oldest in slot 0
    typedef struct packed {
        logic [1:0]              count;
        res_t [MAX_RES-1:0]      res;
    } action_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return (c == CH_SQUOTE) || (c == CH_DQUOTE);
    endfunction

    // kind of a one-byte operator, word kind if none
    function automatic logic [3:0] op_begin(input logic [7:0] c);
        logic [3:0] k;
        unique case (c)
            CH_PIPE:   k = KIND_PIPE;
            CH_AMP:    k = KIND_BACKGROUND;
            CH_LT:     k = KIND_IN;
            CH_GT:     k = KIND_OUT;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_SEMI:   k = KIND_SEMICOLON;
            default:   k = KIND_WORD;
        endcase
        return k;
    endfunction

    // longer operator made by one more byte, word kind if none
    function automatic logic [3:0] op_grow(input logic [3:0] held, input logic [7:0] c);
        logic [3:0] k;
        k = KIND_WORD;
        if (held == KIND_PIPE && c == CH_PIPE)
            k = KIND_OR;
        else if (held == KIND_BACKGROUND && c == CH_AMP)
            k = KIND_AND;
        else if (held == KIND_IN && c == CH_LT)
            k = KIND_HEREDOC;
        else if (held == KIND_HEREDOC && c == CH_LT)
            k = KIND_HERESTRING;
        else if (held == KIND_OUT && c == CH_GT)
            k = KIND_APPEND;
        else if (held == KIND_OUT && c == CH_PIPE)
            k = KIND_CLOBBER;
        return k;
    endfunction

    function automatic res_t mk_res(input logic [7:0] b, input logic has,
                                    input logic fin, input logic [3:0] kind);
        res_t r;
        r.text_byte  = b;
        r.has_byte   = has;
        r.token_end  = fin;
        r.token_kind = kind;
        return r;
    endfunction

endpackage

### src/sct_front.sv
// front end: scan state machine, turns each byte into a bundle of results
module sct_front
    import sct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  cmd_item_t cmd,
    output logic      act_push,
    output action_t   act
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WORD  = 4'b0010,
        S_QUOTE = 4'b0100,
        S_OPER  = 4'b1000
    } scan_mode_t;

    scan_mode_t mode_reg, mode_next;
    logic [3:0] held_reg, held_next;
    logic       nonempty_reg, nonempty_next;

    logic [7:0] c;
    logic       blank, quote;
    logic [3:0] op, grown;
    logic       go_idle;
    logic [1:0] n;
    res_t [MAX_RES-1:0] res;

    assign c     = cmd.ch;
    assign blank = is_blank(c);
    assign quote = is_quote(c);
    assign op    = op_begin(c);
    assign grown = op_grow(held_reg, c);

    // next state and results of the current byte
    always_comb
    begin
        mode_next     = mode_reg;
        held_next     = held_reg;
        nonempty_next = nonempty_reg;
        go_idle       = 1'b0;
        n             = 2'd0;
        res           = '0;

        unique case (mode_reg)
            S_WORD:
            begin
                if (blank)
                begin
                    res[n] = mk_res(8'h00, 1'b0, 1'b1, KIND_WORD);
                    n = n + 2'd1;
                    nonempty_next = 1'b0;
                    mode_next = S_IDLE;
                end
                else if (quote)
                begin
                    mode_next = S_QUOTE;
                end
                else if (op != KIND_WORD)
                begin
                    if (nonempty_reg)
                    begin
                        res[n] = mk_res(8'h00, 1'b0, 1'b1, KIND_WORD);
                        n = n + 2'd1;
                    end
                    nonempty_next = 1'b0;
                    mode_next = S_OPER;
                    held_next = op;
                end
                else
                begin
                    res[n] = mk_res(c, 1'b1, 1'b0, KIND_WORD);
                    n = n + 2'd1;
                    nonempty_next = 1'b1;
                end
            end
            S_QUOTE:
            begin
                if (quote)
                begin
                    mode_next = S_WORD;
                end
                else
                begin
                    res[n] = mk_res(c, 1'b1, 1'b0, KIND_WORD);
                    n = n + 2'd1;
                    nonempty_next = 1'b1;
                end
            end
            S_OPER:
            begin
                if (grown != KIND_WORD)
                begin
                    held_next = grown;
                end
                else
                begin
                    res[n] = mk_res(8'h00, 1'b0, 1'b1, held_reg);
                    n = n + 2'd1;
                    held_next = KIND_WORD;
                    mode_next = S_IDLE;
                    go_idle = 1'b1;
                end
            end
            S_IDLE:
            begin
                go_idle = 1'b1;
            end
            default:
            begin
                mode_next = S_IDLE;
            end
        endcase

        // byte seen between tokens
        if (go_idle && !blank)
        begin
            if (quote)
            begin
                mode_next = S_QUOTE;
                nonempty_next = 1'b0;
            end
            else if (op != KIND_WORD)
            begin
                mode_next = S_OPER;
                held_next = op;
            end
            else
            begin
                mode_next = S_WORD;
                nonempty_next = 1'b1;
                res[n] = mk_res(c, 1'b1, 1'b0, KIND_WORD);
                n = n + 2'd1;
            end
        end

        // end of line flushes an open operator or a non-empty word
        if (cmd.line_end)
        begin
            if (mode_next == S_OPER)
            begin
                res[n] = mk_res(8'h00, 1'b0, 1'b1, held_next);
                n = n + 2'd1;
            end
            else if ((mode_next == S_WORD || mode_next == S_QUOTE) && nonempty_next)
            begin
                res[n] = mk_res(8'h00, 1'b0, 1'b1, KIND_WORD);
                n = n + 2'd1;
            end
            mode_next     = S_IDLE;
            held_next     = KIND_WORD;
            nonempty_next = 1'b0;
        end
    end

    assign act.count = n;
    assign act.res   = res;
    assign act_push  = accept && (n != 2'd0);

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= S_IDLE;
            held_reg     <= KIND_WORD;
            nonempty_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            held_reg     <= held_next;
            nonempty_reg <= nonempty_next;
        end
    end

endmodule

### src/sct_queue.sv
// short queue of result bundles between front and back
module sct_queue
    import sct_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_push,
    input  action_t q_din,
    input  logic    q_pop,
    output logic    q_full,
    output logic    q_valid,
    output action_t q_head
);

    action_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_head  = slot_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (q_push && !q_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (q_pop && !q_push)
            cnt_next = cnt_reg - 1'b1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (q_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (q_push)
            slot_reg[wr_ptr_reg] <= q_din;
    end

endmodule

### src/sct_back.sv
// back end: walks each bundle one result at a time into the output register
module sct_back
    import sct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  action_t     q_head,
    output logic        q_pop,
    input  logic        pop,
    output logic        empty,
    output token_item_t token
);

    logic [1:0]  idx_reg;
    logic        out_valid_reg;
    token_item_t out_reg;
    logic        load, last_res;
    res_t        cur;

    assign cur      = q_head.res[idx_reg];
    assign last_res = (idx_reg == q_head.count - 2'd1);
    assign load     = q_valid && (!out_valid_reg || pop);
    assign q_pop    = load && last_res;
    assign empty    = !out_valid_reg;
    assign token    = out_reg;

    // result index and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= last_res ? 2'd0 : idx_reg + 2'd1;
            if (load)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.text_byte  <= cur.text_byte;
            out_reg.has_byte   <= cur.has_byte;
            out_reg.token_end  <= cur.token_end;
            out_reg.token_kind <= cur.token_kind;
            out_reg.run_last   <= last_res;
        end
    end

endmodule

### src/shell_command_tokenizer_core.sv
// top level of the shell command tokenizer
//
//  channel  | handshake       | transfer when        | payload
//  ---------+-----------------+----------------------+---------------------
//  command  | push / full     | push && !full        | cmd   (cmd_item_t)
//  tokens   | empty / pop     | pop && !empty        | token (token_item_t)
//
//  A byte is taken every cycle while the four-entry bundle queue has room.
//  Each byte yields zero to three results; the back end gives out one result
//  per cycle while pop keeps up, so bytes with several results drain one by one.
//  Each result passes the bundle queue, then the output register, to the token ports.
//  Reset clears the scan state, the queue and the output valid flag at once.
//  full rises only when the queue holds four bundles not yet fully given out.
module shell_command_tokenizer_core
    import sct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  cmd_item_t   cmd,
    output logic        empty,
    input  logic        pop,
    output token_item_t token
);

    logic    accept;
    logic    act_push;
    action_t act;
    logic    q_pop, q_valid;
    action_t q_head;

    assign accept = push && !full;

    // byte scanner
    sct_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .cmd      (cmd),
        .act_push (act_push),
        .act      (act)
    );

    // bundle queue
    sct_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (act_push),
        .q_din   (act),
        .q_pop   (q_pop),
        .q_full  (full),
        .q_valid (q_valid),
        .q_head  (q_head)
    );

    // result sequencer
    sct_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .token   (token)
    );

endmodule
